@@ design/dcc_pkg.sv @@
// Shared types and constants for the dryer cycle controller.
// No dependencies; every other file in design/ imports this package.
package dcc_pkg;

    localparam int TEMP_W    = 12;
    localparam int THRESH_W  = 7;
    localparam int SECONDS_W = 13;
    localparam int COOL_W    = 8;
    localparam int MODE_W    = 3;
    localparam int CLOCK_W   = 6;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;

    // register indexes (byte address is 4 * index)
    localparam logic [2:0] REG_HIGH_UPPER     = 3'd0;
    localparam logic [2:0] REG_HIGH_LOWER     = 3'd1;
    localparam logic [2:0] REG_LOW_UPPER      = 3'd2;
    localparam logic [2:0] REG_LOW_LOWER      = 3'd3;
    localparam logic [2:0] REG_CYCLE_SECONDS  = 3'd4;
    localparam logic [2:0] REG_COOLDOWN_TICKS = 3'd5;

    localparam logic [THRESH_W-1:0]  HIGH_UPPER_RST     = 7'd88;
    localparam logic [THRESH_W-1:0]  HIGH_LOWER_RST     = 7'd82;
    localparam logic [THRESH_W-1:0]  LOW_UPPER_RST      = 7'd54;
    localparam logic [THRESH_W-1:0]  LOW_LOWER_RST      = 7'd49;
    localparam logic [SECONDS_W-1:0] CYCLE_SECONDS_RST  = 13'd1680;
    localparam logic [COOL_W-1:0]    COOLDOWN_TICKS_RST = 8'd61;

    // display modes
    localparam logic [MODE_W-1:0] MODE_TIME  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DOOR  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ERROR = 3'd2;
    localparam logic [MODE_W-1:0] MODE_COOL  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DONE  = 3'd4;

    // reciprocal of 60 scaled by 2^19, exact for values below 2^13
    localparam int               RECIP_SHIFT = 19;
    localparam logic [13:0]      RECIP_60    = 14'd8739;
    localparam logic [7:0]       SIXTY       = 8'd60;

    typedef struct packed {
        logic [THRESH_W-1:0]  high_upper;
        logic [THRESH_W-1:0]  high_lower;
        logic [THRESH_W-1:0]  low_upper;
        logic [THRESH_W-1:0]  low_lower;
        logic [SECONDS_W-1:0] cycle_seconds;
        logic [COOL_W-1:0]    cooldown_ticks;
    } cfg_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature_raw;
        logic                     door_open;
        logic                     second_tick;
        logic                     press_high;
        logic                     press_low;
    } item_t;

    typedef struct packed {
        logic                 relay_main;
        logic                 relay_aux;
        logic [MODE_W-1:0]    display_mode;
        logic [SECONDS_W-1:0] remaining;
    } core_res_t;

endpackage

@@ design/dcc_regs.sv @@
// APB-style configuration registers for the dryer cycle controller.
// Depends on dcc_pkg for register indexes, reset values and cfg_t.
module dcc_regs
    import dcc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [DATA_W-1:0]    pwdata,
    output logic [DATA_W-1:0]    prdata,
    output logic                 pready,
    output cfg_t                 cfg,
    output logic                 cycle_load,
    output logic [SECONDS_W-1:0] cycle_value
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign idx    = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;
    assign cycle_load  = wr_en && (idx == REG_CYCLE_SECONDS);
    // value being written, so the count reloads at the same edge as the register
    assign cycle_value = pwdata[SECONDS_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.high_upper     <= HIGH_UPPER_RST;
            cfg_reg.high_lower     <= HIGH_LOWER_RST;
            cfg_reg.low_upper      <= LOW_UPPER_RST;
            cfg_reg.low_lower      <= LOW_LOWER_RST;
            cfg_reg.cycle_seconds  <= CYCLE_SECONDS_RST;
            cfg_reg.cooldown_ticks <= COOLDOWN_TICKS_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_HIGH_UPPER:     cfg_reg.high_upper     <= pwdata[THRESH_W-1:0];
                REG_HIGH_LOWER:     cfg_reg.high_lower     <= pwdata[THRESH_W-1:0];
                REG_LOW_UPPER:      cfg_reg.low_upper      <= pwdata[THRESH_W-1:0];
                REG_LOW_LOWER:      cfg_reg.low_lower      <= pwdata[THRESH_W-1:0];
                REG_CYCLE_SECONDS:  cfg_reg.cycle_seconds  <= pwdata[SECONDS_W-1:0];
                REG_COOLDOWN_TICKS: cfg_reg.cooldown_ticks <= pwdata[COOL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_HIGH_UPPER:     prdata = {{(DATA_W-THRESH_W){1'b0}}, cfg_reg.high_upper};
            REG_HIGH_LOWER:     prdata = {{(DATA_W-THRESH_W){1'b0}}, cfg_reg.high_lower};
            REG_LOW_UPPER:      prdata = {{(DATA_W-THRESH_W){1'b0}}, cfg_reg.low_upper};
            REG_LOW_LOWER:      prdata = {{(DATA_W-THRESH_W){1'b0}}, cfg_reg.low_lower};
            REG_CYCLE_SECONDS:  prdata = {{(DATA_W-SECONDS_W){1'b0}}, cfg_reg.cycle_seconds};
            REG_COOLDOWN_TICKS: prdata = {{(DATA_W-COOL_W){1'b0}}, cfg_reg.cooldown_ticks};
            default:            prdata = '0;
        endcase
    end

endmodule

@@ design/dcc_core.sv @@
// Cycle state machine: phase, countdown, hysteresis relays and cool-down.
// Depends on dcc_pkg; updates its state once per item when fire is high.
module dcc_core
    import dcc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  item_t                item,
    input  cfg_t                 cfg,
    input  logic                 cycle_load,
    input  logic [SECONDS_W-1:0] cycle_value,
    output core_res_t            res
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_RUN  = 2'd1;
    localparam logic [1:0] PH_COOL = 2'd2;

    logic [1:0]           phase_reg, phase_next;
    logic [SECONDS_W-1:0] rem_reg, rem_next;
    logic [THRESH_W-1:0]  upper_reg, upper_next, lower_reg, lower_next;
    logic                 armed_reg, armed_next;
    logic                 latch_reg, latch_next;
    logic                 main_reg, main_next, aux_reg, aux_next;
    logic [COOL_W-1:0]    cool_reg, cool_next;

    logic [10:0] temp_mag;
    logic        temp_neg, at_upper, at_lower, press_any, done;
    logic [MODE_W-1:0] mode;

    assign temp_neg  = item.temperature_raw[TEMP_W-1];
    assign temp_mag  = item.temperature_raw[TEMP_W-2:0];
    assign press_any = item.press_high || item.press_low;

    always_comb
    begin
        phase_next = phase_reg;
        rem_next   = rem_reg;
        upper_next = upper_reg;
        lower_next = lower_reg;
        armed_next = armed_reg;
        latch_next = latch_reg;
        main_next  = main_reg;
        aux_next   = aux_reg;
        cool_next  = cool_reg;
        mode       = MODE_TIME;
        done       = 1'b0;
        at_upper   = temp_mag >= {upper_reg, 4'b0000};
        at_lower   = temp_mag <= {lower_reg, 4'b0000};

        if (phase_reg == PH_IDLE)
        begin
            if (press_any)
            begin
                upper_next = item.press_low ? cfg.low_upper : cfg.high_upper;
                lower_next = item.press_low ? cfg.low_lower : cfg.high_lower;
                armed_next = 1'b1;
            end
            if (item.door_open)
            begin
                main_next  = 1'b0;
                aux_next   = 1'b0;
                armed_next = 1'b0;
                mode       = MODE_DOOR;
            end
            else if (armed_next && (rem_reg != '0))
            begin
                phase_next = PH_RUN;
            end
        end

        if (phase_next == PH_RUN)
        begin
            // an item that starts the run compares against the thresholds it just loaded
            if (phase_reg == PH_IDLE)
            begin
                at_upper = temp_mag >= {upper_next, 4'b0000};
                at_lower = temp_mag <= {lower_next, 4'b0000};
            end
            if (item.door_open)
            begin
                main_next  = 1'b0;
                aux_next   = 1'b0;
                armed_next = 1'b0;
                phase_next = PH_IDLE;
                mode       = MODE_DOOR;
            end
            else if (temp_neg)
            begin
                main_next = 1'b0;
                aux_next  = 1'b0;
                mode      = MODE_ERROR;
            end
            else
            begin
                if (!latch_reg && at_upper)
                begin
                    main_next  = 1'b1;
                    aux_next   = 1'b0;
                    latch_next = 1'b1;
                end
                if (at_lower)
                begin
                    main_next  = 1'b1;
                    aux_next   = 1'b1;
                    latch_next = 1'b0;
                end
                if (press_any)
                begin
                    upper_next = item.press_low ? cfg.low_upper : cfg.high_upper;
                    lower_next = item.press_low ? cfg.low_lower : cfg.high_lower;
                end
                if (item.second_tick && (rem_reg != '0))
                begin
                    rem_next = rem_reg - 1'b1;
                    if (rem_next == '0)
                    begin
                        phase_next = PH_COOL;
                        cool_next  = '0;
                        aux_next   = 1'b0;
                        mode       = MODE_COOL;
                    end
                end
            end
        end
        else if (phase_reg == PH_COOL)
        begin
            aux_next = 1'b0;
            mode     = MODE_COOL;
            if (item.second_tick)
            begin
                if (cool_reg != {COOL_W{1'b1}})
                begin
                    cool_next = cool_reg + 1'b1;
                end
                done = cool_next >= cfg.cooldown_ticks;
            end
        end

        res.relay_main   = main_next;
        res.relay_aux    = aux_next;
        res.display_mode = mode;
        res.remaining    = rem_next;

        if (done)
        begin
            res.relay_main   = 1'b0;
            res.relay_aux    = 1'b0;
            res.display_mode = MODE_DONE;
            res.remaining    = '0;
            phase_next = PH_IDLE;
            rem_next   = cfg.cycle_seconds;
            upper_next = '0;
            lower_next = '0;
            armed_next = 1'b0;
            latch_next = 1'b0;
            main_next  = 1'b0;
            aux_next   = 1'b0;
            cool_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            rem_reg   <= CYCLE_SECONDS_RST;
            upper_reg <= '0;
            lower_reg <= '0;
            armed_reg <= 1'b0;
            latch_reg <= 1'b0;
            main_reg  <= 1'b0;
            aux_reg   <= 1'b0;
            cool_reg  <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            rem_reg   <= rem_next;
            upper_reg <= upper_next;
            lower_reg <= lower_next;
            armed_reg <= armed_next;
            latch_reg <= latch_next;
            main_reg  <= main_next;
            aux_reg   <= aux_next;
            cool_reg  <= cool_next;
        end
        else if (cycle_load && (phase_reg == PH_IDLE))
        begin
            rem_reg <= cycle_value;
        end
    end

endmodule

@@ design/dcc_fmt.sv @@
// Splits a remaining-seconds count into minutes mod 60 and seconds for display.
// Depends on dcc_pkg; divides by 60 through a reciprocal multiply.
module dcc_fmt
    import dcc_pkg::*;
(
    input  logic [SECONDS_W-1:0] remaining,
    output logic [CLOCK_W-1:0]   minutes_left,
    output logic [CLOCK_W-1:0]   seconds_left
);

    logic [SECONDS_W+13:0] prod;
    logic [7:0]            quot;
    logic [SECONDS_W-1:0]  quot_x60;
    logic [SECONDS_W-1:0]  rem_sec;
    logic [7:0]            mins;

    assign prod     = remaining * RECIP_60;
    assign quot     = prod[RECIP_SHIFT+7:RECIP_SHIFT];
    assign quot_x60 = SECONDS_W'({quot, 6'b0} - {4'b0, quot, 2'b0});
    assign rem_sec  = remaining - quot_x60;

    // quotient stays below 137, so two conditional subtracts give mod 60
    always_comb
    begin
        if (quot >= (SIXTY << 1))
        begin
            mins = quot - (SIXTY << 1);
        end
        else if (quot >= SIXTY)
        begin
            mins = quot - SIXTY;
        end
        else
        begin
            mins = quot;
        end
    end

    assign minutes_left = mins[CLOCK_W-1:0];
    assign seconds_left = rem_sec[CLOCK_W-1:0];

endmodule

@@ design/dryer_cycle_controller_top.sv @@
// Dryer cycle controller: a three-register pipeline (input, state update, display
// format) around dcc_core, with dcc_regs for configuration. Depends on dcc_pkg.
//
// The controller takes one item per clock while the output side does not stall
// and gives one result per item, through the input, state and output registers.
// The cycle state (phase, countdown, thresholds, relays, cool-down count) updates
// as an item leaves the input register, which sets the one-item-per-cycle rate;
// the next stage converts the remaining seconds to minutes and seconds. Writes to
// cycle_seconds while idle and no item fires also reload the remaining count.
module dryer_cycle_controller_top
    import dcc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [TEMP_W-1:0] temperature_raw,
    input  logic                     door_open,
    input  logic                     second_tick,
    input  logic                     press_high,
    input  logic                     press_low,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     relay_main,
    output logic                     relay_aux,
    output logic [MODE_W-1:0]        display_mode,
    output logic [CLOCK_W-1:0]       minutes_left,
    output logic [CLOCK_W-1:0]       seconds_left
);

    cfg_t      cfg;
    logic      cycle_load;
    logic [SECONDS_W-1:0] cycle_value;
    logic      in_v_reg, mid_v_reg, out_v_reg;
    item_t     in_reg;
    core_res_t mid_reg, core_res;
    logic      out_adv, mid_adv, in_adv, fire;
    logic [CLOCK_W-1:0] fmt_min, fmt_sec;
    logic               main_reg, aux_reg;
    logic [MODE_W-1:0]  mode_reg;
    logic [CLOCK_W-1:0] min_reg, sec_reg;

    dcc_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .cfg         (cfg),
        .cycle_load  (cycle_load),
        .cycle_value (cycle_value)
    );

    // advance a stage when the one after it is empty or moving
    assign out_adv  = !out_v_reg || !out_stall;
    assign mid_adv  = !mid_v_reg || out_adv;
    assign fire     = in_v_reg && mid_adv;
    assign in_adv   = !in_v_reg || mid_adv;
    assign in_stall = !in_adv;

    dcc_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .item        (in_reg),
        .cfg         (cfg),
        .cycle_load  (cycle_load),
        .cycle_value (cycle_value),
        .res         (core_res)
    );

    dcc_fmt u_fmt (
        .remaining    (mid_reg.remaining),
        .minutes_left (fmt_min),
        .seconds_left (fmt_sec)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            mid_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (in_adv)
            begin
                in_v_reg <= in_valid;
            end
            if (mid_adv)
            begin
                mid_v_reg <= in_v_reg;
            end
            if (out_adv)
            begin
                out_v_reg <= mid_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_adv && in_valid)
        begin
            in_reg.temperature_raw <= temperature_raw;
            in_reg.door_open       <= door_open;
            in_reg.second_tick     <= second_tick;
            in_reg.press_high      <= press_high;
            in_reg.press_low       <= press_low;
        end
        if (fire)
        begin
            mid_reg <= core_res;
        end
        if (out_adv && mid_v_reg)
        begin
            main_reg <= mid_reg.relay_main;
            aux_reg  <= mid_reg.relay_aux;
            mode_reg <= mid_reg.display_mode;
            min_reg  <= fmt_min;
            sec_reg  <= fmt_sec;
        end
    end

    assign out_valid    = out_v_reg;
    assign relay_main   = main_reg;
    assign relay_aux    = aux_reg;
    assign display_mode = mode_reg;
    assign minutes_left = min_reg;
    assign seconds_left = sec_reg;

endmodule
